>>> rtl/header_tail_packet_framer_macros.svh
// ----------------------------------------------------------------------------
// Framer assertion macros
// Immediate-consequence and next-cycle property wrappers on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef HEADER_TAIL_PACKET_FRAMER_MACROS_SVH
`define HEADER_TAIL_PACKET_FRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Consequence must hold in the same cycle as the antecedent
`define HTPF_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("framer assertion failed");

// Consequence must hold in the cycle after the antecedent
`define HTPF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");

`else

`define HTPF_ASSERT_SAME(name, ante, cons)
`define HTPF_ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> rtl/htpf_pkg.sv
// ----------------------------------------------------------------------------
// Framer package
// Word types, the byte-job descriptor and register codes shared by the framer.
// ----------------------------------------------------------------------------
package htpf_pkg;

	// Mark counters are four bits wide and hold counts up to 15 bytes
	localparam int MARK_CNT_W = 4;

	// Register indexes on the configuration port
	localparam logic [2:0] CFG_FRAME_MODE      = 3'd0;
	localparam logic [2:0] CFG_CHECKSUM_ENABLE = 3'd1;
	localparam logic [2:0] CFG_HEADER_COUNT    = 3'd2;
	localparam logic [2:0] CFG_HEADER_WORD     = 3'd3;
	localparam logic [2:0] CFG_TRAILER_COUNT   = 3'd4;
	localparam logic [2:0] CFG_TRAILER_WORD    = 3'd5;

	// Frame layouts
	localparam logic MODE_TRAILER = 1'b0;
	localparam logic MODE_LENGTH  = 1'b1;

	// Input word
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       byte_present;
		logic       frame_start;
		logic       frame_end;
		logic [7:0] payload_length;
	} item_t;

	// Result word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_last;
	} result_t;

	// Everything the back end must send for one input word, in order
	typedef struct packed {
		logic [MARK_CNT_W-1:0] hdr_cnt;
		logic [31:0]           hdr_word;
		logic                  len_en;
		logic [7:0]            len_byte;
		logic                  dat_en;
		logic [7:0]            dat_byte;
		logic                  cks_en;
		logic [7:0]            cks_byte;
		logic [MARK_CNT_W-1:0] trl_cnt;
		logic [31:0]           trl_word;
		logic                  last;
	} desc_t;

endpackage

>>> rtl/htpf_front.sv
// ----------------------------------------------------------------------------
// Framer front end
// Holds the registers and frame state, and turns each input word into a
// descriptor of the bytes it causes.
// ----------------------------------------------------------------------------
module htpf_front #(
	parameter int MAX_MARK_BYTES = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	input  htpf_pkg::item_t item,
	input  logic            take,
	output htpf_pkg::desc_t desc,
	output logic            desc_push
);
	import htpf_pkg::*;

	localparam logic [MARK_CNT_W-1:0] MAX_CNT = MARK_CNT_W'(MAX_MARK_BYTES);

	logic        frame_mode_q;
	logic        checksum_enable_q;
	logic [2:0]  header_count_q;
	logic [31:0] header_word_q;
	logic [2:0]  trailer_count_q;
	logic [31:0] trailer_word_q;

	logic        in_frame_q;
	logic [7:0]  sum_q;

	logic        open_w;
	logic        data_w;
	logic        close_w;
	logic [7:0]  sum_base;
	logic [8:0]  sum_raw;
	logic [7:0]  sum_after;
	logic [MARK_CNT_W-1:0] hdr_sat;
	logic [MARK_CNT_W-1:0] trl_sat;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q      <= MODE_TRAILER;
			checksum_enable_q <= 1'b0;
			header_count_q    <= 3'd2;
			header_word_q     <= 32'h0000_0A0D;
			trailer_count_q   <= 3'd2;
			trailer_word_q    <= 32'h0000_0D0A;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_MODE:      frame_mode_q      <= cfg_data[0];
				CFG_CHECKSUM_ENABLE: checksum_enable_q <= cfg_data[0];
				CFG_HEADER_COUNT:    header_count_q    <= cfg_data[2:0];
				CFG_HEADER_WORD:     header_word_q     <= cfg_data;
				CFG_TRAILER_COUNT:   trailer_count_q   <= cfg_data[2:0];
				CFG_TRAILER_WORD:    trailer_word_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Classify the word against the frame state
	assign open_w  = item.frame_start || in_frame_q;
	assign data_w  = item.byte_present && open_w;
	assign close_w = item.frame_end && open_w;

	// End-around-carry sum; a start clears the running sum first
	assign sum_base  = item.frame_start ? 8'd0 : sum_q;
	assign sum_raw   = {1'b0, sum_base} + {1'b0, item.payload_byte};
	assign sum_after = data_w ? (sum_raw[7:0] + {7'd0, sum_raw[8]}) : sum_base;

	// Clamp mark counts to the supported length
	assign hdr_sat = ({1'b0, header_count_q} > MAX_CNT) ? MAX_CNT
		: MARK_CNT_W'(header_count_q);
	assign trl_sat = ({1'b0, trailer_count_q} > MAX_CNT) ? MAX_CNT
		: MARK_CNT_W'(trailer_count_q);

	// Build the descriptor
	always_comb begin
		desc          = '0;
		desc.hdr_word = header_word_q;
		desc.trl_word = trailer_word_q;
		desc.dat_byte = item.payload_byte;
		desc.cks_byte = sum_after;
		desc.len_byte = item.payload_length + (checksum_enable_q ? 8'd2 : 8'd1);
		if (item.frame_start) begin
			desc.hdr_cnt = hdr_sat;
			desc.len_en  = (frame_mode_q == MODE_LENGTH);
		end
		desc.dat_en = data_w;
		if (close_w) begin
			desc.cks_en  = checksum_enable_q;
			desc.trl_cnt = (frame_mode_q == MODE_TRAILER) ? trl_sat : '0;
			desc.last    = 1'b1;
		end
	end

	// Words that cause no byte never reach the queue
	assign desc_push = take && ((desc.hdr_cnt != '0) || desc.len_en || desc.dat_en
		|| desc.cks_en || (desc.trl_cnt != '0));

	// Advance the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			sum_q      <= 8'd0;
		end else if (take) begin
			in_frame_q <= open_w && !item.frame_end;
			sum_q      <= close_w ? 8'd0 : sum_after;
		end
	end

endmodule

>>> rtl/htpf_queue.sv
// ----------------------------------------------------------------------------
// Framer descriptor queue
// Small first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module htpf_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  htpf_pkg::desc_t wr_data,
	input  logic            rd,
	output htpf_pkg::desc_t rd_data,
	output logic            full,
	output logic            avail
);
	import htpf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	desc_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == FULL_CNT);
	assign avail   = (cnt_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/htpf_back.sv
// ----------------------------------------------------------------------------
// Framer back end
// Walks one descriptor a byte per cycle while the result register can load it.
// ----------------------------------------------------------------------------
module htpf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  htpf_pkg::desc_t   desc,
	input  logic              desc_avail,
	output logic              desc_pop,
	output htpf_pkg::result_t result,
	output logic              empty,
	input  logic              pop
);
	import htpf_pkg::*;

	desc_t      w_q;
	logic       w_v_q;
	desc_t      w_next;
	logic [7:0] cur_byte;
	logic       w_done;
	logic       out_load;
	logic       advance;
	result_t    out_q;
	logic       out_v_q;

	// Pick the next byte in frame order and retire it from the working copy
	always_comb begin
		w_next   = w_q;
		cur_byte = 8'd0;
		priority if (w_q.hdr_cnt != '0) begin
			cur_byte        = w_q.hdr_word[7:0];
			w_next.hdr_cnt  = w_q.hdr_cnt - 1'b1;
			w_next.hdr_word = w_q.hdr_word >> 8;
		end else if (w_q.len_en) begin
			cur_byte      = w_q.len_byte;
			w_next.len_en = 1'b0;
		end else if (w_q.dat_en) begin
			cur_byte      = w_q.dat_byte;
			w_next.dat_en = 1'b0;
		end else if (w_q.cks_en) begin
			cur_byte      = w_q.cks_byte;
			w_next.cks_en = 1'b0;
		end else if (w_q.trl_cnt != '0) begin
			cur_byte        = w_q.trl_word[7:0];
			w_next.trl_cnt  = w_q.trl_cnt - 1'b1;
			w_next.trl_word = w_q.trl_word >> 8;
		end else begin
			// Nothing left in the working copy
			cur_byte = 8'd0;
		end
	end

	assign w_done = (w_next.hdr_cnt == '0) && !w_next.len_en && !w_next.dat_en
		&& !w_next.cks_en && (w_next.trl_cnt == '0);

	assign out_load = !out_v_q || pop;
	assign advance  = w_v_q && out_load;
	assign desc_pop = desc_avail && (!w_v_q || (advance && w_done));

	// Hold the working copy
	always_ff @(posedge clk) begin
		if (desc_pop) begin
			w_q <= desc;
		end else if (advance) begin
			w_q <= w_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_v_q <= 1'b0;
		end else if (desc_pop) begin
			w_v_q <= 1'b1;
		end else if (advance) begin
			w_v_q <= !w_done;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.out_byte   <= cur_byte;
			out_q.frame_last <= w_q.last && w_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= w_v_q;
		end
	end

	assign result = out_q;
	assign empty  = !out_v_q;

endmodule

>>> rtl/header_tail_packet_framer.sv
// Header/trailer packet framer: payload words in on a push/full channel, framed bytes
// out on an empty/pop channel, registers written on a cfg valid/ready channel.
// Each input word may open a frame (header bytes, plus a length byte in length
// mode), carry one payload byte, and close the frame (checksum byte if enabled,
// plus trailer bytes in trailer mode). The final byte of a closing word has
// frame_last set. Payload outside a frame is dropped.
// A pushed word passes the descriptor queue, the back end's working copy and
// the result register before its first byte shows with empty low. The input
// side takes one word per cycle while the four-deep descriptor queue has room;
// the sequencer sends one byte per cycle while its result register is free,
// loading the next descriptor with the last byte; byteless words never queue.
// When pop stays low the result register holds and the queue fills; full rises
// once all four descriptor slots are taken. Reset empties the queue, closes any
// open frame, clears the checksum and restores the register reset values.
// Registers should be written only while no word is still in flight.
// ----------------------------------------------------------------------------
// Header/trailer packet framer top level
// Front end, descriptor queue and byte sequencer.
// ----------------------------------------------------------------------------
`include "header_tail_packet_framer_macros.svh"

module header_tail_packet_framer #(
	parameter int MAX_MARK_BYTES = 4,
	parameter int QUEUE_DEPTH    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  htpf_pkg::item_t   item,
	input  logic              push,
	output logic              full,
	output htpf_pkg::result_t result,
	output logic              empty,
	input  logic              pop
);
	import htpf_pkg::*;

	logic  take;
	desc_t front_desc;
	logic  desc_push;
	desc_t queue_desc;
	logic  desc_pop;
	logic  queue_avail;
	logic  queue_desc_live;

	assign take = push && !full;

	// Classify words
	htpf_front #(
		.MAX_MARK_BYTES(MAX_MARK_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.take      (take),
		.desc      (front_desc),
		.desc_push (desc_push)
	);

	// Decouple front and back
	htpf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (desc_push),
		.wr_data (front_desc),
		.rd      (desc_pop),
		.rd_data (queue_desc),
		.full    (full),
		.avail   (queue_avail)
	);

	// Send bytes
	htpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc       (queue_desc),
		.desc_avail (queue_avail),
		.desc_pop   (desc_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

	// Queue head still has a byte to send
	assign queue_desc_live = (queue_desc.hdr_cnt != '0) || queue_desc.len_en
		|| queue_desc.dat_en || queue_desc.cks_en || (queue_desc.trl_cnt != '0);

	// A descriptor is only written when the queue has a free slot
	`HTPF_ASSERT_SAME(a_push_room, desc_push, !full)

	// The sequencer only takes a descriptor that is there
	`HTPF_ASSERT_SAME(a_pop_avail, desc_pop, queue_avail)

	// Every queued descriptor carries at least one byte
	`HTPF_ASSERT_SAME(a_desc_nonempty, desc_pop, queue_desc_live)

	// Taking a descriptor leaves a byte ready for the result register next cycle
	`HTPF_ASSERT_NEXT(a_pop_feeds, desc_pop, u_back.w_v_q)

endmodule
